// ===== src/smms_pkg.sv =====
`timescale 1ns / 1ps
// Package for the servo mode motion sequencer: widths, mode, phase and
// register codes, reset values, scan windows and the angle helper functions.
// No dependencies.
package smms_pkg;

    localparam int ANGLE_W     = 8;
    localparam int PULSE_W     = 12;
    localparam int MODE_W      = 2;
    localparam int PHASE_W     = 2;
    localparam int RND_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;
    localparam int DIGIT_W     = 2;
    localparam int PROD_W      = ANGLE_W + PULSE_W;
    localparam int MUL_STEPS   = ANGLE_W / DIGIT_W;
    localparam int DIV_STEPS   = PULSE_W / DIGIT_W;
    localparam int CNT_W       = 3;
    localparam int SUM_W       = PULSE_W + 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    // Modes
    localparam logic [MODE_W-1:0] MODE_HOME  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EMERG = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSVD  = 2'd3;

    // Scan phases
    localparam logic [PHASE_W-1:0] PH_LEFT    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_MID_L   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_RIGHT   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_MID_R   = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOME_ANGLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHAKE_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHAKE_LEFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHAKE_RIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_ZERO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_HOME  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_FULL  = 3'd7;

    // Register reset values
    localparam logic [ANGLE_W-1:0] RST_HOME_ANGLE  = 8'd90;
    localparam logic [ANGLE_W-1:0] RST_NORMAL_STEP = 8'd2;
    localparam logic [ANGLE_W-1:0] RST_SHAKE_STEP  = 8'd10;
    localparam logic [ANGLE_W-1:0] RST_SHAKE_LEFT  = 8'd45;
    localparam logic [ANGLE_W-1:0] RST_SHAKE_RIGHT = 8'd135;
    localparam logic [PULSE_W-1:0] RST_PULSE_ZERO  = 12'd500;
    localparam logic [PULSE_W-1:0] RST_PULSE_HOME  = 12'd1500;
    localparam logic [PULSE_W-1:0] RST_PULSE_FULL  = 12'd2500;

    // Scan windows
    localparam logic [ANGLE_W-1:0] LEFT_LOW    = 8'd30;
    localparam logic [ANGLE_W-1:0] LEFT_HIGH   = 8'd60;
    localparam logic [ANGLE_W-1:0] MIDDLE_LOW  = 8'd80;
    localparam logic [ANGLE_W-1:0] MIDDLE_HIGH = 8'd100;
    localparam logic [ANGLE_W-1:0] RIGHT_LOW   = 8'd120;
    localparam logic [ANGLE_W-1:0] RIGHT_HIGH  = 8'd150;

    localparam logic [ANGLE_W-1:0] FULL_ANGLE = 8'd180;
    localparam logic [PULSE_W-1:0] PULSE_CEIL = 12'd3000;

    typedef struct packed {
        logic               start;
        logic [PULSE_W-1:0] mcand;
        logic [ANGLE_W-1:0] mplier;
        logic [ANGLE_W-1:0] divisor;
    } md_request_t;

    typedef struct packed {
        logic               done;
        logic [PULSE_W-1:0] quotient;
    } md_result_t;

    function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W:0] a);
        logic [ANGLE_W-1:0] r;
        r = (a > {1'b0, FULL_ANGLE}) ? FULL_ANGLE : a[ANGLE_W-1:0];
        return r;
    endfunction

    // lo + ((rnd * span) >> 16), span forced to one for an inverted window
    function automatic logic [ANGLE_W-1:0] draw_angle(input logic [ANGLE_W-1:0] lo,
                                                      input logic [ANGLE_W-1:0] hi,
                                                      input logic [RND_W-1:0] rnd);
        logic [ANGLE_W-1:0]       span;
        logic [RND_W+ANGLE_W-1:0] prod;
        logic [ANGLE_W:0]         sum;
        span = (hi >= lo) ? ANGLE_W'(hi - lo + 8'd1) : 8'd1;
        prod = rnd * span;
        sum  = {1'b0, lo} + {1'b0, prod[RND_W+ANGLE_W-1:RND_W]};
        return clamp_angle(sum);
    endfunction

    function automatic logic [ANGLE_W-1:0] slew_angle(input logic [ANGLE_W-1:0] cur,
                                                      input logic [ANGLE_W-1:0] tgt,
                                                      input logic [ANGLE_W-1:0] step);
        logic [ANGLE_W:0]   up;
        logic [ANGLE_W-1:0] gap;
        logic [ANGLE_W-1:0] r;
        up  = {1'b0, cur} + {1'b0, step};
        gap = cur - tgt;
        r   = cur;
        if (cur < tgt) begin
            r = (up > {1'b0, tgt}) ? tgt : up[ANGLE_W-1:0];
        end else if (cur > tgt) begin
            r = (gap <= step) ? tgt : ANGLE_W'(cur - step);
        end
        return r;
    endfunction

endpackage

// ===== src/smms_muldiv.sv =====
`timescale 1ns / 1ps
// Digit-serial multiply then divide, two bits a cycle: (mcand * mplier) / divisor.
// Depends on smms_pkg. The caller guarantees mplier <= divisor, so the
// quotient fits in PULSE_W bits.
module smms_muldiv (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  smms_pkg::md_request_t req,
    output smms_pkg::md_result_t  res
);
    import smms_pkg::*;

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } md_state_t;

    md_state_t            state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [PROD_W-1:0]    mcand_reg, mcand_next;
    logic [ANGLE_W-1:0]   mplier_reg, mplier_next;
    logic [ANGLE_W-1:0]   div_reg, div_next;
    logic [ANGLE_W-1:0]   rem_reg, rem_next;
    logic [PULSE_W-1:0]   quo_reg, quo_next;
    logic                 done_reg, done_next;
    logic [PROD_W-1:0]    prod_sum;
    logic [ANGLE_W-1:0]   div_rem;
    logic [PULSE_W-1:0]   div_quo;
    logic [ANGLE_W:0]     trial;

    // one digit of the product: add the shifted multiplicand per set bit
    always_comb begin
        prod_sum = prod_reg;
        for (int i = 0; i < DIGIT_W; i++) begin
            if (mplier_reg[i]) begin
                prod_sum = prod_sum + (mcand_reg << i);
            end
        end
    end

    // one digit of restoring division
    always_comb begin
        div_rem = rem_reg;
        div_quo = quo_reg;
        trial   = '0;
        for (int i = 0; i < DIGIT_W; i++) begin
            trial   = {div_rem, div_quo[PULSE_W-1]};
            div_quo = {div_quo[PULSE_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                trial      = trial - {1'b0, div_reg};
                div_quo[0] = 1'b1;
            end
            div_rem = trial[ANGLE_W-1:0];
        end
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        prod_next   = prod_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            MD_IDLE: begin
                if (req.start) begin
                    prod_next   = '0;
                    mcand_next  = PROD_W'(req.mcand);
                    mplier_next = req.mplier;
                    div_next    = req.divisor;
                    cnt_next    = '0;
                    state_next  = MD_MUL;
                end
            end
            MD_MUL: begin
                prod_next   = prod_sum;
                mcand_next  = mcand_reg << DIGIT_W;
                mplier_next = mplier_reg >> DIGIT_W;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                    // high part is below the divisor, low part feeds the quotient
                    rem_next   = prod_sum[PROD_W-1:PULSE_W];
                    quo_next   = prod_sum[PULSE_W-1:0];
                    cnt_next   = '0;
                    state_next = MD_DIV;
                end
            end
            MD_DIV: begin
                rem_next = div_rem;
                quo_next = div_quo;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
        prod_reg   <= prod_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule

// ===== src/servo_mode_motion_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the servo mode motion sequencer: mode entry rules, slew,
// scan draws and the angle to pulse mapping. Depends on smms_pkg and smms_muldiv.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  s_       | in        | s_tvalid/s_tready  | s_tdata: requested_mode, random_word
//  m_       | out       | m_tvalid/m_tready  | m_tdata: angle_now, pulse_us,
//           |           |                    |          angle_goal, phase_now
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// One request at a time: from acceptance back to ready the sequencer runs the step,
// the map setup, 4 multiply digits, 6 divide digits, the finish, the load and the
// return, when the result register is free. The digits run in the two-bit serial
// multiply-divide. The result register lets the next request enter while a
// result waits; a stalled result holds the sequencer in its last cycle.
// aresetn is synchronous, active low, and restores the register defaults.
module servo_mode_motion_sequencer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [1:0] requested_mode, [17:2] random_word, [23:18] zero
    input  logic [smms_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] angle_now, [19:8] pulse_us, [27:20] angle_goal, [29:28] phase_now,
    // [31:30] zero
    output logic [smms_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [smms_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [smms_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import smms_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_STEP = 5'b00010,
        S_MAP  = 5'b00100,
        S_WAIT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t              state_reg, state_next;

    // configuration
    logic [ANGLE_W-1:0]  home_reg, nstep_reg, sstep_reg, sleft_reg, sright_reg;
    logic [PULSE_W-1:0]  p0_reg, ph_reg, pf_reg;

    // sequencer state
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [ANGLE_W-1:0]  cur_reg, cur_next;
    logic [ANGLE_W-1:0]  tgt_reg, tgt_next;

    // captured request
    logic [MODE_W-1:0]   req_reg;
    logic [RND_W-1:0]    rnd_reg;

    // mapping
    logic [PULSE_W-1:0]  base_reg, base_next;
    logic                neg_reg, neg_next;
    logic [PULSE_W-1:0]  pulse_reg, pulse_next;

    // result register
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    md_request_t         md_req;
    md_result_t          md_res;

    // step datapath
    logic [MODE_W-1:0]   eff_mode;
    logic [ANGLE_W-1:0]  left_c, right_c, home_c;
    logic [ANGLE_W-1:0]  draw_l, draw_m, draw_r;
    logic [ANGLE_W-1:0]  tgt_e, step_sel;
    logic [PHASE_W-1:0]  phase_e, phase_adv;

    // mapping datapath
    logic                map_lower;
    logic [PULSE_W:0]    map_diff;
    logic [PULSE_W-1:0]  map_mag;
    logic [SUM_W-1:0]    fin_sum;
    logic                load_out;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Configuration writes: the bus must write only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            home_reg   <= RST_HOME_ANGLE;
            nstep_reg  <= RST_NORMAL_STEP;
            sstep_reg  <= RST_SHAKE_STEP;
            sleft_reg  <= RST_SHAKE_LEFT;
            sright_reg <= RST_SHAKE_RIGHT;
            p0_reg     <= RST_PULSE_ZERO;
            ph_reg     <= RST_PULSE_HOME;
            pf_reg     <= RST_PULSE_FULL;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_HOME_ANGLE:  home_reg   <= cfg_data[ANGLE_W-1:0];
                REG_NORMAL_STEP: nstep_reg  <= cfg_data[ANGLE_W-1:0];
                REG_SHAKE_STEP:  sstep_reg  <= cfg_data[ANGLE_W-1:0];
                REG_SHAKE_LEFT:  sleft_reg  <= cfg_data[ANGLE_W-1:0];
                REG_SHAKE_RIGHT: sright_reg <= cfg_data[ANGLE_W-1:0];
                REG_PULSE_ZERO:  p0_reg     <= cfg_data;
                REG_PULSE_HOME:  ph_reg     <= cfg_data;
                REG_PULSE_FULL:  pf_reg     <= cfg_data;
            endcase
        end
    end

    // Step: the reserved mode code keeps the previous mode and skips entry.
    always_comb begin
        eff_mode = (req_reg == MODE_RSVD) ? mode_reg : req_reg;
        left_c   = clamp_angle({1'b0, sleft_reg});
        right_c  = clamp_angle({1'b0, sright_reg});
        home_c   = clamp_angle({1'b0, home_reg});
        draw_l   = draw_angle(LEFT_LOW, LEFT_HIGH, rnd_reg);
        draw_m   = draw_angle(MIDDLE_LOW, MIDDLE_HIGH, rnd_reg);
        draw_r   = draw_angle(RIGHT_LOW, RIGHT_HIGH, rnd_reg);

        // entry rule on a change of mode
        tgt_e   = tgt_reg;
        phase_e = phase_reg;
        if (eff_mode != mode_reg) begin
            case (eff_mode)
                MODE_HOME: tgt_e = home_c;
                MODE_SCAN: begin
                    phase_e = PH_LEFT;
                    tgt_e   = draw_l;
                end
                default:   tgt_e = left_c;
            endcase
        end

        phase_adv = phase_e + 1'b1;
        step_sel  = (eff_mode == MODE_EMERG) ? sstep_reg : nstep_reg;

        cur_next   = cur_reg;
        tgt_next   = tgt_e;
        phase_next = phase_e;
        case (eff_mode)
            MODE_HOME: begin
                tgt_next = home_c;
                cur_next = slew_angle(cur_reg, home_c, step_sel);
            end
            MODE_SCAN: begin
                if (cur_reg != tgt_e) begin
                    cur_next = slew_angle(cur_reg, tgt_e, step_sel);
                end else begin
                    // arrived: advance the phase and draw from its window
                    phase_next = phase_adv;
                    case (phase_adv)
                        PH_LEFT:  tgt_next = draw_l;
                        PH_RIGHT: tgt_next = draw_r;
                        PH_MID_L, PH_MID_R: tgt_next = draw_m;
                        default:  tgt_next = draw_m;
                    endcase
                end
            end
            default: begin
                if (cur_reg != tgt_e) begin
                    cur_next = slew_angle(cur_reg, tgt_e, step_sel);
                end else begin
                    // arrived: toggle between the shake ends
                    tgt_next = (tgt_e == left_c) ? right_c : left_c;
                end
            end
        endcase
        mode_next = eff_mode;
    end

    // Map setup: pick the segment, split the slope into sign and magnitude.
    always_comb begin
        map_lower = (cur_reg <= home_reg);
        md_req.start = (state_reg == S_MAP);
        if (map_lower) begin
            base_next      = p0_reg;
            map_diff       = {1'b0, ph_reg} - {1'b0, p0_reg};
            md_req.mplier  = cur_reg;
            md_req.divisor = home_reg;
            if (home_reg == '0) begin
                // zero-width lower segment: pulse_at_zero exactly
                map_diff       = '0;
                md_req.divisor = ANGLE_W'(1);
            end
        end else begin
            base_next      = ph_reg;
            map_diff       = {1'b0, pf_reg} - {1'b0, ph_reg};
            md_req.mplier  = cur_reg - home_reg;
            md_req.divisor = FULL_ANGLE - home_reg;
        end
        neg_next     = map_diff[PULSE_W];
        map_mag      = neg_next ? PULSE_W'(-map_diff) : map_diff[PULSE_W-1:0];
        md_req.mcand = map_mag;
    end

    smms_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .res     (md_res)
    );

    // Finish: add the signed quotient, saturate to the pulse range.
    always_comb begin
        fin_sum = neg_reg ? SUM_W'({2'b00, base_reg} - {2'b00, md_res.quotient})
                          : SUM_W'({2'b00, base_reg} + {2'b00, md_res.quotient});
        if (fin_sum[SUM_W-1]) begin
            pulse_next = '0;
        end else if (fin_sum > SUM_W'(PULSE_CEIL)) begin
            pulse_next = PULSE_CEIL;
        end else begin
            pulse_next = fin_sum[PULSE_W-1:0];
        end
    end

    assign load_out = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_STEP;
            S_STEP: state_next = S_MAP;
            S_MAP:  state_next = S_WAIT;
            S_WAIT: if (md_res.done) state_next = S_DONE;
            S_DONE: if (load_out) state_next = S_IDLE;
        endcase
    end

    // Result register: drop valid once taken, reload when free.
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, phase_reg, tgt_reg, pulse_reg, cur_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            mode_reg     <= MODE_HOME;
            phase_reg    <= PH_LEFT;
            cur_reg      <= clamp_angle({1'b0, RST_HOME_ANGLE});
            tgt_reg      <= clamp_angle({1'b0, RST_HOME_ANGLE});
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (state_reg == S_STEP) begin
                mode_reg  <= mode_next;
                phase_reg <= phase_next;
                cur_reg   <= cur_next;
                tgt_reg   <= tgt_next;
            end
        end
        if (s_tvalid && s_tready) begin
            req_reg <= s_tdata[MODE_W-1:0];
            rnd_reg <= s_tdata[MODE_W+RND_W-1:MODE_W];
        end
        if (state_reg == S_MAP) begin
            base_reg <= base_next;
            neg_reg  <= neg_next;
        end
        if ((state_reg == S_WAIT) && md_res.done) begin
            pulse_reg <= pulse_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ===== src/smms_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for servo_mode_motion_sequencer, bound to the top level.
// Depends on smms_pkg.
module smms_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [smms_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import smms_pkg::*;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time: ready drops after an acceptance
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // angles stay within the servo travel
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] <= FULL_ANGLE) && (m_tdata[27:20] <= FULL_ANGLE))
        else $error("angle out of range");

    // pulse stays saturated
    a_pulse_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[19:8] <= PULSE_CEIL)
        else $error("pulse out of range");

endmodule

bind servo_mode_motion_sequencer smms_checker u_smms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/servo_mode_motion_sequencer_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for servo_mode_motion_sequencer: bursty control ticks in,
// stalled readings out, each reading checked against an in-bench servo model.
// Depends on smms_pkg and the sequencer RTL.
module servo_mode_motion_sequencer_test;
    import smms_pkg::*;

    localparam int QUIET_LIMIT   = 3000;  // cycles with no request moved anywhere
    localparam int SETTLE_CYCLES = 20;    // margin for the block to go idle after the last reading
    localparam int LONG_HOLD     = 300;
    localparam int MAX_PRINTS    = 40;
    localparam int FULL_DEG      = FULL_ANGLE;
    localparam int PULSE_MAX     = PULSE_CEIL;
    localparam int PULSE_LSB     = ANGLE_W;
    localparam int GOAL_LSB      = ANGLE_W + PULSE_W;
    localparam int PHASE_LSB     = GOAL_LSB + ANGLE_W;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [RND_W-1:0]  word;
    } servo_tick_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_now;
        logic [PULSE_W-1:0] pulse_us;
        logic [ANGLE_W-1:0] angle_goal;
        logic [PHASE_W-1:0] phase_now;
    } servo_reading_t;

    typedef enum logic [1:0] {RX_OPEN, RX_TOGGLE, RX_RANDOM, RX_SPARSE} rx_style_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Register copies, as the block holds them after reset
    int home_deg        = RST_HOME_ANGLE;
    int normal_step     = RST_NORMAL_STEP;
    int shake_step      = RST_SHAKE_STEP;
    int shake_left_deg  = RST_SHAKE_LEFT;
    int shake_right_deg = RST_SHAKE_RIGHT;
    int zero_us         = RST_PULSE_ZERO;
    int home_us         = RST_PULSE_HOME;
    int full_us         = RST_PULSE_FULL;

    // Servo state
    logic [MODE_W-1:0]  prev_mode   = MODE_HOME;
    logic [PHASE_W-1:0] sweep_phase = PH_LEFT;
    int                 pos_deg     = RST_HOME_ANGLE;
    int                 aim_deg     = RST_HOME_ANGLE;

    servo_tick_t    queued_ticks[$];
    servo_reading_t awaited_outputs[$];
    servo_reading_t seen_reading, due_reading;

    int ticks_sent     = 0;
    int outputs_seen   = 0;
    int mismatches     = 0;
    int settings_used  = 0;
    int mode_entries   = 0;
    int scan_arrivals  = 0;
    int shake_reverses = 0;
    int quiet_cycles   = 0;

    int        burst_left = 0;
    int        gap_left   = 0;
    int        hold_left  = 0;
    int        style_left = 0;
    bit        long_hold_done = 1'b0;
    rx_style_t stall_style = RX_OPEN;
    logic [4:0] rx_count = '0;

    servo_mode_motion_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int limit_deg(input int a);
        return (a > FULL_DEG) ? FULL_DEG : a;
    endfunction

    // lo + ((word * span) >> 16) within the window of the given phase
    function automatic int scan_target(input logic [PHASE_W-1:0] ph,
                                       input logic [RND_W-1:0] word);
        int lo, hi, span;
        case (ph)
            PH_LEFT: begin
                lo = LEFT_LOW;
                hi = LEFT_HIGH;
            end
            PH_RIGHT: begin
                lo = RIGHT_LOW;
                hi = RIGHT_HIGH;
            end
            default: begin
                lo = MIDDLE_LOW;
                hi = MIDDLE_HIGH;
            end
        endcase
        span = (hi >= lo) ? hi - lo + 1 : 1;
        return limit_deg(lo + ((int'(word) * span) >> 16));
    endfunction

    function automatic int slew_deg(input int from, input int to, input int step);
        if (from < to)
            return (from + step > to) ? to : from + step;
        if (from > to)
            return (from - to <= step) ? to : from - step;
        return from;
    endfunction

    // Two straight segments split at the home angle, saturated to the pulse range
    function automatic int pulse_for(input int deg);
        int a, r;
        a = limit_deg(deg);
        if (a <= home_deg) begin
            r = (home_deg == 0) ? zero_us : zero_us + (a * (home_us - zero_us)) / home_deg;
        end else begin
            r = home_us + ((a - home_deg) * (full_us - home_us)) / (FULL_DEG - home_deg);
        end
        if (r < 0)
            r = 0;
        if (r > PULSE_MAX)
            r = PULSE_MAX;
        return r;
    endfunction

    // Run one control tick on the model state and return the reading it gives
    function automatic servo_reading_t advance_servo(input logic [MODE_W-1:0] req,
                                                     input logic [RND_W-1:0] word);
        servo_reading_t r;
        logic [MODE_W-1:0] mode;
        int left, right;
        mode  = (req == MODE_RSVD) ? prev_mode : req;
        left  = limit_deg(shake_left_deg);
        right = limit_deg(shake_right_deg);
        if (mode != prev_mode) begin
            mode_entries++;
            case (mode)
                MODE_HOME: aim_deg = limit_deg(home_deg);
                MODE_SCAN: begin
                    sweep_phase = PH_LEFT;
                    aim_deg     = scan_target(sweep_phase, word);
                end
                default: aim_deg = left;
            endcase
            prev_mode = mode;
        end
        case (mode)
            MODE_HOME: begin
                aim_deg = limit_deg(home_deg);
                pos_deg = slew_deg(pos_deg, aim_deg, normal_step);
            end
            MODE_SCAN: begin
                if (pos_deg != aim_deg) begin
                    pos_deg = slew_deg(pos_deg, aim_deg, normal_step);
                end else begin
                    scan_arrivals++;
                    sweep_phase = sweep_phase + 1'b1;
                    aim_deg     = scan_target(sweep_phase, word);
                end
            end
            default: begin
                if (pos_deg != aim_deg) begin
                    pos_deg = slew_deg(pos_deg, aim_deg, shake_step);
                end else begin
                    shake_reverses++;
                    aim_deg = (aim_deg == left) ? right : left;
                end
            end
        endcase
        r.angle_now  = ANGLE_W'(pos_deg);
        r.pulse_us   = PULSE_W'(pulse_for(pos_deg));
        r.angle_goal = ANGLE_W'(aim_deg);
        r.phase_now  = sweep_phase;
        return r;
    endfunction

    task automatic report_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("reading %0d: %s is %0d, expected %0d",
                                   outputs_seen, name, got, want));
    endtask

    task automatic queue_tick(input logic [MODE_W-1:0] mode, input logic [RND_W-1:0] word);
        servo_tick_t t;
        t.mode = mode;
        t.word = word;
        queued_ticks.push_back(t);
    endtask

    // Write one register and mirror it; the 8-bit registers get junk above bit 7
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input int val);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(val);
        if (idx < REG_PULSE_ZERO)
            data[CFG_DATA_W-1:ANGLE_W] = 4'($urandom_range(0, 15));
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_HOME_ANGLE:  home_deg        = data[ANGLE_W-1:0];
            REG_NORMAL_STEP: normal_step     = data[ANGLE_W-1:0];
            REG_SHAKE_STEP:  shake_step      = data[ANGLE_W-1:0];
            REG_SHAKE_LEFT:  shake_left_deg  = data[ANGLE_W-1:0];
            REG_SHAKE_RIGHT: shake_right_deg = data[ANGLE_W-1:0];
            REG_PULSE_ZERO:  zero_us         = data;
            REG_PULSE_HOME:  home_us         = data;
            REG_PULSE_FULL:  full_us         = data;
            default: ;
        endcase
    endtask

    task automatic program_servo(input int home, input int nstep, input int sstep,
                                 input int left, input int right,
                                 input int p0, input int ph, input int pf);
        settings_used++;
        write_setting(REG_HOME_ANGLE, home);
        write_setting(REG_NORMAL_STEP, nstep);
        write_setting(REG_SHAKE_STEP, sstep);
        write_setting(REG_SHAKE_LEFT, left);
        write_setting(REG_SHAKE_RIGHT, right);
        write_setting(REG_PULSE_ZERO, p0);
        write_setting(REG_PULSE_HOME, ph);
        write_setting(REG_PULSE_FULL, pf);
    endtask

    // Steps are mostly small so that scan targets are reached over many ticks
    task automatic program_random();
        program_servo($urandom_range(1, 179),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 180) : $urandom_range(1, 12),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 180) : $urandom_range(1, 20),
                      $urandom_range(0, 180), $urandom_range(0, 180),
                      $urandom_range(0, 3000), $urandom_range(0, 3000), $urandom_range(0, 3000));
    endtask

    // Mostly runs of one mode long enough to reach targets, with stray modes mixed in
    task automatic queue_mode_runs(input int count);
        int added, run, k;
        bit noisy;
        logic [MODE_W-1:0] mode;
        logic [RND_W-1:0]  word;
        added = 0;
        while (added < count) begin
            mode  = MODE_W'($urandom_range(0, 2));
            run   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 45);
            noisy = ($urandom_range(0, 7) == 0);
            for (k = 0; k < run && added < count; k++) begin
                case ($urandom_range(0, 9))
                    0:       word = '0;
                    1:       word = '1;
                    default: word = RND_W'($urandom());
                endcase
                if (noisy || $urandom_range(0, 15) == 0)
                    queue_tick(MODE_W'($urandom_range(0, 3)), word);
                else
                    queue_tick(mode, word);
                added++;
            end
        end
    endtask

    // Wait until every tick has been sent and answered, then let the block go idle
    task automatic settle();
        do @(negedge aclk);
        while (queued_ticks.size() != 0 || s_tvalid || awaited_outputs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Tick driver: predict on acceptance, then offer the next tick unless in a gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_outputs.push_back(advance_servo(s_tdata[MODE_W-1:0],
                                                        s_tdata[MODE_W +: RND_W]));
                ticks_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (queued_ticks.size() != 0) begin
                    s_tdata  <= IN_TDATA_W'({queued_ticks[0].word, queued_ticks[0].mode});
                    s_tvalid <= 1'b1;
                    void'(queued_ticks.pop_front());
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Reading sink: one long hold-off once, otherwise a changing stall style
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && outputs_seen >= 250) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                stall_style = rx_style_t'($urandom_range(0, 3));
                style_left  = $urandom_range(32, 200);
            end else begin
                style_left--;
            end
            rx_count = rx_count + 1'b1;
            case (stall_style)
                RX_OPEN:   m_tready <= 1'b1;
                RX_TOGGLE: m_tready <= rx_count[1];
                RX_RANDOM: m_tready <= ($urandom_range(0, 9) < 7);
                default:   m_tready <= (rx_count < 5'd3);
            endcase
        end
    end

    // Reading monitor: compare each accepted reading with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            outputs_seen++;
            if (awaited_outputs.size() == 0) begin
                report_error($sformatf("reading %0d arrived with none awaited (tdata %h)",
                                       outputs_seen, m_tdata));
            end else begin
                due_reading             = awaited_outputs.pop_front();
                seen_reading.angle_now  = m_tdata[0 +: ANGLE_W];
                seen_reading.pulse_us   = m_tdata[PULSE_LSB +: PULSE_W];
                seen_reading.angle_goal = m_tdata[GOAL_LSB +: ANGLE_W];
                seen_reading.phase_now  = m_tdata[PHASE_LSB +: PHASE_W];
                check_field("angle_now", seen_reading.angle_now, due_reading.angle_now);
                check_field("pulse_us", seen_reading.pulse_us, due_reading.pulse_us);
                check_field("angle_goal", seen_reading.angle_goal, due_reading.angle_goal);
                check_field("phase_now", seen_reading.phase_now, due_reading.phase_now);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("servo_mode_motion_sequencer_test failed");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: ignored mode first, then home again, then one entry into scan and one into emergency
        queue_tick(MODE_RSVD, 16'h0000);
        queue_tick(MODE_HOME, 16'hFFFF);
        queue_tick(MODE_SCAN, 16'h0000);
        queue_tick(MODE_EMERG, 16'h1234);
        settle();

        // Full-range steps so that arrivals, phase cycling and shake reversals come quickly
        settings_used++;
        write_setting(REG_NORMAL_STEP, FULL_DEG);
        write_setting(REG_SHAKE_STEP, FULL_DEG);
        queue_tick(MODE_SCAN, 16'hFFFF);
        queue_tick(MODE_SCAN, 16'h0000);
        queue_tick(MODE_SCAN, 16'hFFFF);
        queue_tick(MODE_SCAN, 16'h8000);
        queue_tick(MODE_SCAN, 16'h0000);
        queue_tick(MODE_RSVD, 16'hFFFF);
        queue_tick(MODE_SCAN, 16'hFFFF);
        queue_tick(MODE_EMERG, 16'h0000);
        queue_tick(MODE_EMERG, 16'h0000);
        queue_tick(MODE_EMERG, 16'h0000);
        queue_tick(MODE_RSVD, 16'h0000);
        queue_tick(MODE_EMERG, 16'h0000);
        queue_tick(MODE_HOME, 16'h0000);
        queue_tick(MODE_HOME, 16'hFFFF);
        queue_tick(MODE_RSVD, 16'hFFFF);
        queue_tick(MODE_SCAN, 16'h0000);
        queue_tick(MODE_EMERG, 16'hFFFF);
        queue_tick(MODE_HOME, 16'h0000);
        settle();

        program_random();
        queue_mode_runs(110);
        settle();

        // Low home angle, widest shake, mapping that falls past home
        program_servo(1, 180, 180, 0, 180, 0, 3000, 0);
        queue_mode_runs(100);
        settle();

        // High home angle, single-degree steps, shake ends swapped
        program_servo(179, 1, 1, 180, 0, 3000, 0, 3000);
        queue_mode_runs(100);
        settle();

        // Zero steps, targets above full scale, pulse registers beyond the ceiling
        program_servo(200, 0, 0, 250, 181, 4095, 4095, 0);
        queue_mode_runs(50);
        settle();

        // Home at zero and both shake ends on the same angle
        program_servo(0, 7, 13, 100, 100, 3000, 100, 4000);
        queue_mode_runs(100);
        settle();

        // All-ones home, steps and left shake end: every angle maps through the lower segment
        program_servo(255, 255, 255, 255, 200, 4095, 0, 4095);
        queue_mode_runs(50);
        settle();

        program_random();
        queue_mode_runs(110);
        settle();

        $display("Drove %0d ticks under %0d register settings: %0d mode entries,",
                 ticks_sent, settings_used, mode_entries);
        $display("%0d scan arrivals, %0d shake reversals; %0d readings compared, %0d errors.",
                 scan_arrivals, shake_reverses, outputs_seen, mismatches);
        if (mismatches == 0)
            $display("servo_mode_motion_sequencer_test passed");
        else
            $display("servo_mode_motion_sequencer_test failed");
        $finish;
    end

endmodule
